// ===== rtl/lrgs_pkg.sv =====
// lrgs_pkg: widths, register indexes and shared types of the gradient step block
// no dependencies; used by lrgs_mul, lrgs_div and linear_regression_gradient_step
`default_nettype none

package lrgs_pkg;

   localparam int DATA_W   = 32;
   localparam int ACC_W    = 64;
   localparam int LR_W     = 16;
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LR     = 2'd2;

   localparam logic [LR_W-1:0] LR_RESET = 16'd655;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/lrgs_mul.sv =====
// lrgs_mul: shared signed 33x33 multiplier with registered product
// depends on lrgs_pkg
`default_nettype none

module lrgs_mul (
   input  wire logic                                  clock,
   input  wire logic signed [lrgs_pkg::MUL_W-1:0]     mul_a,
   input  wire logic signed [lrgs_pkg::MUL_W-1:0]     mul_b,
   output logic signed [lrgs_pkg::PROD_W-1:0]         prod
);

   logic signed [lrgs_pkg::PROD_W-1:0] prod_ff;
   logic signed [lrgs_pkg::PROD_W-1:0] prod_in;

   assign prod_in = lrgs_pkg::PROD_W'(mul_a) * lrgs_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== rtl/lrgs_div.sv =====
// lrgs_div: radix-2 restoring divider, signed 64-bit dividend by unsigned count
// gives quotient magnitude (truncated) and sign; depends on lrgs_pkg
`default_nettype none

module lrgs_div #(
   parameter int DIVISOR_W = 11
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [lrgs_pkg::ACC_W-1:0]   dividend,
   input  wire logic [DIVISOR_W-1:0]                divisor,
   output lrgs_pkg::div_status_type                 status,
   output logic [lrgs_pkg::ACC_W-1:0]               quotient,
   output logic                                     negative
);

   localparam int CNT_W = $clog2(lrgs_pkg::ACC_W);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [lrgs_pkg::ACC_W-1:0]      quo_ff, quo_in;
   logic [DIVISOR_W-1:0]            rem_ff, rem_in;
   logic [DIVISOR_W-1:0]            den_ff, den_in;
   logic                            neg_ff, neg_in;
   logic [DIVISOR_W:0]              trial;
   logic [DIVISOR_W:0]              trial_diff;
   logic                            fits;

   always_comb begin
      trial      = {rem_ff, quo_ff[lrgs_pkg::ACC_W-1]};
      trial_diff = trial - {1'b0, den_ff};
      fits       = trial >= {1'b0, den_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      neg_in     = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[lrgs_pkg::ACC_W-1];
         quo_in  = dividend[lrgs_pkg::ACC_W-1] ? lrgs_pkg::ACC_W'(-dividend)
                                                : lrgs_pkg::ACC_W'(dividend);
      end else if (busy_ff) begin
         rem_in = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[lrgs_pkg::ACC_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(lrgs_pkg::ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign negative    = neg_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held more than one cycle");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff))
      else $error("divider done without a division running");
`endif

endmodule

`default_nettype wire

// ===== rtl/linear_regression_gradient_step.sv =====
// linear_regression_gradient_step: one gradient-descent step of simple linear regression
// sequencer and datapath around lrgs_mul and lrgs_div; depends on lrgs_pkg
//
//  channel | ports                                   | handshake
//  req     | sample_x, sample_y, last_sample         | req_valid / req_stall
//  rsp     | new_weight, new_bias, mean_sq_error, ovf | rsp_valid / rsp_stall
//  csr     | csr_index, csr_data                     | csr_valid / csr_ready
//
// a pair goes through accept, then residual and three products on the shared multiplier
// a marked pair adds three 64-step divisions on the shared divider
//   plus two split multiplies by the learning rate for the step sizes
// reset clears accumulators, count and flags and loads the register defaults
// a waiting result does not block new pairs; only the next result waits for rsp_stall
`default_nettype none

module linear_regression_gradient_step #(
   parameter int MAX_SAMPLES = 1024
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic signed [lrgs_pkg::DATA_W-1:0]      req_sample_x,
   input  wire logic signed [lrgs_pkg::DATA_W-1:0]      req_sample_y,
   input  wire logic                                    req_last_sample,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [lrgs_pkg::DATA_W-1:0]           rsp_new_weight,
   output logic signed [lrgs_pkg::DATA_W-1:0]           rsp_new_bias,
   output logic [lrgs_pkg::DATA_W-1:0]                  rsp_mean_sq_error,
   output logic                                         rsp_overflowed,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [lrgs_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [lrgs_pkg::DATA_W-1:0]             csr_data
);

   localparam int CW = $clog2(MAX_SAMPLES + 1);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_ERR      = 12'b0000_0000_0010,
      ST_MUL_EX   = 12'b0000_0000_0100,
      ST_ACC_EX   = 12'b0000_0000_1000,
      ST_ACC_SQ   = 12'b0000_0001_0000,
      ST_DIV_GO   = 12'b0000_0010_0000,
      ST_DIV_WAIT = 12'b0000_0100_0000,
      ST_MUL_LO   = 12'b0000_1000_0000,
      ST_MUL_HI   = 12'b0001_0000_0000,
      ST_STEP     = 12'b0010_0000_0000,
      ST_APPLY    = 12'b0100_0000_0000,
      ST_OUT      = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      PH_WEIGHT = 2'd0,
      PH_BIAS   = 2'd1,
      PH_MSE    = 2'd2
   } phase_type;

   localparam logic [48:0] G_LIMIT  = 49'h1_0000_0000_0000;
   localparam logic [63:0] MSE_MAX  = 64'h0000_0000_FFFF_FFFF;

   function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return {1'b1, a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
      end
      return {1'b0, s};
   endfunction

   function automatic logic [32:0] sat_to_32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         return {1'b1, 32'h7FFF_FFFF};
      end
      if (v < -64'sh0000_0000_8000_0000) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[31:0]};
   endfunction

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic                     last_ff, last_in;
   logic signed [31:0]       x_ff, x_in;
   logic signed [31:0]       y_ff, y_in;
   logic signed [31:0]       err_ff, err_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [63:0]       sum_ex_ff, sum_ex_in;
   logic signed [63:0]       sum_err_ff, sum_err_in;
   logic signed [63:0]       sum_sq_ff, sum_sq_in;
   logic                     sat_ff, sat_in;
   logic signed [31:0]       weight_ff, weight_in;
   logic signed [31:0]       bias_ff, bias_in;
   logic [15:0]              lr_ff, lr_in;
   logic [49:0]              m_ff, m_in;
   logic                     neg_ff, neg_in;
   logic [47:0]              lo_ff, lo_in;
   logic [49:0]              step_ff, step_in;
   logic signed [31:0]       new_w_ff, new_w_in;
   logic signed [31:0]       new_b_ff, new_b_in;
   logic [31:0]              mse_ff, mse_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]       rsp_w_ff, rsp_w_in;
   logic signed [31:0]       rsp_b_ff, rsp_b_in;
   logic [31:0]              rsp_mse_ff, rsp_mse_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic signed [lrgs_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [lrgs_pkg::PROD_W-1:0]  prod;
   logic                                div_start;
   logic signed [63:0]                  div_dividend;
   lrgs_pkg::div_status_type            div_stat;
   logic [63:0]                         div_quo;
   logic                                div_neg;

   logic signed [47:0]       prod_shift;
   logic signed [63:0]       prod_ext;
   logic signed [63:0]       err_sum;
   logic [32:0]              err_sat;
   logic [64:0]              acc_ex, acc_err, acc_sq;
   logic [48:0]              q_clamp;
   logic signed [31:0]       apply_param;
   logic signed [63:0]       apply_diff;
   logic [32:0]              apply_sat;

   lrgs_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   lrgs_div #(
      .DIVISOR_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .status   (div_stat),
      .quotient (div_quo),
      .negative (div_neg)
   );

   // operand select for the shared multiplier
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            mul_a = lrgs_pkg::MUL_W'(weight_ff);
            mul_b = lrgs_pkg::MUL_W'(req_sample_x);
         end
         ST_MUL_EX: begin
            mul_a = lrgs_pkg::MUL_W'(err_ff);
            mul_b = lrgs_pkg::MUL_W'(x_ff);
         end
         ST_ACC_EX: begin
            mul_a = lrgs_pkg::MUL_W'(err_ff);
            mul_b = lrgs_pkg::MUL_W'(err_ff);
         end
         ST_MUL_LO: begin
            mul_a = {1'b0, m_ff[31:0]};
            mul_b = {17'b0, lr_ff};
         end
         ST_MUL_HI: begin
            mul_a = {15'b0, m_ff[49:32]};
            mul_b = {17'b0, lr_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      case (phase_ff)
         PH_WEIGHT: div_dividend = sum_ex_ff;
         PH_BIAS:   div_dividend = sum_err_ff;
         default:   div_dividend = sum_sq_ff;
      endcase
   end

   always_comb begin
      prod_shift  = prod[63:16];
      prod_ext    = {{16{prod_shift[47]}}, prod_shift};
      err_sum     = prod_ext + 64'(bias_ff) - 64'(y_ff);
      err_sat     = sat_to_32(err_sum);
      acc_ex      = sat_add(sum_ex_ff, prod_ext);
      acc_err     = sat_add(sum_err_ff, 64'(err_ff));
      acc_sq      = sat_add(sum_sq_ff, prod_ext);
      q_clamp     = (div_quo > 64'(G_LIMIT)) ? G_LIMIT : div_quo[48:0];
      apply_param = (phase_ff == PH_WEIGHT) ? weight_ff : bias_ff;
      apply_diff  = neg_ff ? 64'(apply_param) + {14'b0, step_ff}
                           : 64'(apply_param) - {14'b0, step_ff};
      apply_sat   = sat_to_32(apply_diff);
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      last_in      = last_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      err_in       = err_ff;
      count_in     = count_ff;
      sum_ex_in    = sum_ex_ff;
      sum_err_in   = sum_err_ff;
      sum_sq_in    = sum_sq_ff;
      sat_in       = sat_ff;
      weight_in    = weight_ff;
      bias_in      = bias_ff;
      lr_in        = lr_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      lo_in        = lo_ff;
      step_in      = step_ff;
      new_w_in     = new_w_ff;
      new_b_in     = new_b_ff;
      mse_in       = mse_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_mse_in   = rsp_mse_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      div_start    = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            lrgs_pkg::CSR_WEIGHT: weight_in = csr_data;
            lrgs_pkg::CSR_BIAS:   bias_in   = csr_data;
            lrgs_pkg::CSR_LR:     lr_in     = csr_data[15:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_sample_x;
               y_in    = req_sample_y;
               last_in = req_last_sample;
               if (count_ff < CW'(MAX_SAMPLES)) begin
                  state_in = ST_ERR;
               end else begin
                  // set is full: drop the pair
                  sat_in = 1'b1;
                  if (req_last_sample) begin
                     phase_in = PH_WEIGHT;
                     state_in = ST_DIV_GO;
                  end
               end
            end
         end
         ST_ERR: begin
            err_in   = err_sat[31:0];
            sat_in   = sat_ff | err_sat[32];
            state_in = ST_MUL_EX;
         end
         ST_MUL_EX: begin
            sum_err_in = acc_err[63:0];
            sat_in     = sat_ff | acc_err[64];
            state_in   = ST_ACC_EX;
         end
         ST_ACC_EX: begin
            sum_ex_in = acc_ex[63:0];
            sat_in    = sat_ff | acc_ex[64];
            state_in  = ST_ACC_SQ;
         end
         ST_ACC_SQ: begin
            sum_sq_in = acc_sq[63:0];
            sat_in    = sat_ff | acc_sq[64];
            count_in  = count_ff + 1'b1;
            if (last_ff) begin
               phase_in = PH_WEIGHT;
               state_in = ST_DIV_GO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               if (phase_ff == PH_MSE) begin
                  if (div_quo > MSE_MAX) begin
                     mse_in = 32'hFFFF_FFFF;
                     sat_in = 1'b1;
                  end else begin
                     mse_in = div_quo[31:0];
                  end
                  state_in = ST_OUT;
               end else begin
                  m_in     = {q_clamp, 1'b0};
                  neg_in   = div_neg;
                  state_in = ST_MUL_LO;
               end
            end
         end
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            lo_in    = prod[47:0];
            state_in = ST_STEP;
         end
         ST_STEP: begin
            step_in  = {prod[33:0], 16'b0} + {18'b0, lo_ff[47:16]};
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            sat_in = sat_ff | apply_sat[32];
            if (phase_ff == PH_WEIGHT) begin
               new_w_in = apply_sat[31:0];
               phase_in = PH_BIAS;
            end else begin
               new_b_in = apply_sat[31:0];
               phase_in = PH_MSE;
            end
            state_in = ST_DIV_GO;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_w_in     = new_w_ff;
               rsp_b_in     = new_b_ff;
               rsp_mse_in   = mse_ff;
               rsp_ovf_in   = sat_ff;
               count_in     = '0;
               sum_ex_in    = '0;
               sum_err_in   = '0;
               sum_sq_in    = '0;
               sat_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_WEIGHT;
         count_ff     <= '0;
         sum_ex_ff    <= '0;
         sum_err_ff   <= '0;
         sum_sq_ff    <= '0;
         sat_ff       <= 1'b0;
         weight_ff    <= '0;
         bias_ff      <= '0;
         lr_ff        <= lrgs_pkg::LR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sum_ex_ff    <= sum_ex_in;
         sum_err_ff   <= sum_err_in;
         sum_sq_ff    <= sum_sq_in;
         sat_ff       <= sat_in;
         weight_ff    <= weight_in;
         bias_ff      <= bias_in;
         lr_ff        <= lr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff    <= last_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      err_ff     <= err_in;
      m_ff       <= m_in;
      neg_ff     <= neg_in;
      lo_ff      <= lo_in;
      step_ff    <= step_in;
      new_w_ff   <= new_w_in;
      new_b_ff   <= new_b_in;
      mse_ff     <= mse_in;
      rsp_w_ff   <= rsp_w_in;
      rsp_b_ff   <= rsp_b_in;
      rsp_mse_ff <= rsp_mse_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign csr_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_weight    = rsp_w_ff;
   assign rsp_new_bias      = rsp_b_ff;
   assign rsp_mean_sq_error = rsp_mse_ff;
   assign rsp_overflowed    = rsp_ovf_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES))
      else $error("pair count beyond limit");
   a_sq_nonneg: assert property (@(posedge clock) disable iff (reset)
      !sum_sq_ff[63])
      else $error("squared error sum negative");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result beat raised outside output state");
   a_div_only_when_closing: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_DIV_WAIT))
      else $error("divider running outside closing sequence");
`endif

endmodule

`default_nettype wire
